// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker in dbd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define DBD_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define DBD_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dbd_pkg.sv =====
`default_nettype none
package dbd_pkg;

    localparam int unsigned MAX_YEAR = 9999;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned COUNT_W  = 22;

    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [8:0] DAYS_BEFORE [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [COUNT_W-1:0] serial;
        logic               ok;
    } t_serial;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] dbm;
        dbm = 9'd0;
        if (m >= MON_JAN && m <= MON_DEC) begin
            dbm = DAYS_BEFORE[4'(m - MON_JAN)];
        end
        return dbm;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dbd_serial.sv =====
`default_nettype none
// Three-stage serial day number of one date, with a validity check.
module dbd_serial (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire  [dbd_pkg::YEAR_W-1:0]     i_year,
    input  wire  [dbd_pkg::MONTH_W-1:0]    i_month,
    input  wire  [dbd_pkg::DAY_W-1:0]      i_day,
    output dbd_pkg::t_serial               o_res
);
    import dbd_pkg::*;

    // stage A: year / 100 by reciprocal
    logic [YEAR_W-1:0]  r_a_year;
    logic [MONTH_W-1:0] r_a_month;
    logic [DAY_W-1:0]   r_a_day;
    logic [7:0]         r_a_q;
    logic [26:0]        n_a_prod;

    assign n_a_prod = 27'(i_year) * 27'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_year  <= i_year;
            r_a_month <= i_month;
            r_a_day   <= i_day;
            r_a_q     <= n_a_prod[RECIP_SHIFT +: 8];
        end
    end

    // stage B: leap rule, validity, century counts of year-1
    logic [YEAR_W-1:0]  w_b_hund;
    logic [YEAR_W-1:0]  w_b_rem;
    logic               w_b_rem_zero;
    logic               w_b_leap;
    logic               w_b_ok;
    logic [YEAR_W-1:0]  r_b_p;
    logic [7:0]         r_b_c100;
    logic               r_b_leap;
    logic               r_b_ok;
    logic [MONTH_W-1:0] r_b_month;
    logic [DAY_W-1:0]   r_b_day;

    always_comb begin
        w_b_hund     = 14'(r_a_q) * 14'd100;
        w_b_rem      = r_a_year - w_b_hund;
        w_b_rem_zero = (w_b_rem[6:0] == 7'd0);
        w_b_leap     = (r_a_year[1:0] == 2'd0 && !w_b_rem_zero)
                    || (w_b_rem_zero && r_a_q[1:0] == 2'd0);
        w_b_ok       = (r_a_year >= 14'd1) && (r_a_year <= 14'(MAX_YEAR))
                    && (r_a_month >= MON_JAN) && (r_a_month <= MON_DEC)
                    && (r_a_day >= 5'd1)
                    && (r_a_day <= month_len(r_a_month, w_b_leap));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_p     <= r_a_year - 14'd1;
            // (y-1)/100 drops by one exactly when y is a multiple of 100
            r_b_c100  <= r_a_q - 8'(w_b_rem_zero);
            r_b_leap  <= w_b_leap;
            r_b_ok    <= w_b_ok;
            r_b_month <= r_a_month;
            r_b_day   <= r_a_day;
        end
    end

    // stage C: sum of year, month and day parts
    logic [COUNT_W-1:0] w_c_years;
    logic [COUNT_W-1:0] w_c_rest;
    logic [COUNT_W-1:0] r_c_serial;
    logic               r_c_ok;

    always_comb begin
        w_c_years = 22'(r_b_p) * 22'd365 + 22'(r_b_p >> 2)
                  - 22'(r_b_c100) + 22'(r_b_c100 >> 2);
        w_c_rest  = 22'(days_before(r_b_month))
                  + 22'(r_b_leap && (r_b_month > MON_FEB))
                  + 22'(r_b_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_serial <= w_c_years + w_c_rest;
            r_c_ok     <= r_b_ok;
        end
    end

    assign o_res.serial = r_c_serial;
    assign o_res.ok     = r_c_ok;

endmodule
`default_nettype wire

// ===== hdl/days_between_dates.sv =====
`default_nettype none
// Days between two Gregorian dates. Each beat carries two dates; the result gives the
// day count from the first to the second, is_ordered when the first is strictly earlier,
// and is_invalid when either date does not exist (count 0 unless is_ordered). The datapath
// is a four-stage pipeline (reciprocal divide by 100, leap and range checks, serial day
// sum, compare and subtract into the output register): a beat enters every cycle while
// the output is not stalled, and its result passes stages A, B and C and is then
// presented from the output register. A stall on the output freezes the whole
// pipeline, so o_stall follows i_stall while a result is held.
module days_between_dates (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [dbd_pkg::YEAR_W-1:0]   i_first_year,
    input  wire  [dbd_pkg::MONTH_W-1:0]  i_first_month,
    input  wire  [dbd_pkg::DAY_W-1:0]    i_first_day,
    input  wire  [dbd_pkg::YEAR_W-1:0]   i_second_year,
    input  wire  [dbd_pkg::MONTH_W-1:0]  i_second_month,
    input  wire  [dbd_pkg::DAY_W-1:0]    i_second_day,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [dbd_pkg::COUNT_W-1:0]  o_day_count,
    output logic                         o_is_ordered,
    output logic                         o_is_invalid
);
    import dbd_pkg::*;

    logic    w_en;
    t_serial w_first;
    t_serial w_second;
    logic    r_vld_a;
    logic    r_vld_b;
    logic    r_vld_c;
    logic    r_out_vld;

    logic [COUNT_W-1:0] r_count;
    logic               r_ordered;
    logic               r_invalid;
    logic               w_both_ok;
    logic               w_before;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;

    dbd_serial u_first (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (i_first_year),
        .i_month (i_first_month),
        .i_day   (i_first_day),
        .o_res   (w_first)
    );

    dbd_serial u_second (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (i_second_year),
        .i_month (i_second_month),
        .i_day   (i_second_day),
        .o_res   (w_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
            r_vld_c   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld_a   <= i_valid;
            r_vld_b   <= r_vld_a;
            r_vld_c   <= r_vld_b;
            r_out_vld <= r_vld_c;
        end
    end

    assign w_both_ok = w_first.ok && w_second.ok;
    assign w_before  = w_first.serial < w_second.serial;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_invalid <= !w_both_ok;
            r_ordered <= w_both_ok && w_before;
            r_count   <= (w_both_ok && w_before) ? (w_second.serial - w_first.serial)
                                                 : '0;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_day_count  = r_count;
    assign o_is_ordered = r_ordered;
    assign o_is_invalid = r_invalid;

endmodule
`default_nettype wire

// ===== hdl/dbd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module dbd_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire  [dbd_pkg::COUNT_W-1:0]  o_day_count,
    input wire                          o_is_ordered,
    input wire                          o_is_invalid
);
    `DBD_IMPLIES(a_invalid_zero, o_valid && o_is_invalid,
        !o_is_ordered && o_day_count == '0, "invalid beat with count or order set")
    `DBD_IMPLIES(a_unordered_zero, o_valid && !o_is_ordered,
        o_day_count == '0, "unordered beat with nonzero count")
    `DBD_IMPLIES(a_ordered_nonzero, o_valid && o_is_ordered,
        o_day_count != '0, "ordered beat with zero count")
    `DBD_NEXT(a_hold_on_stall, o_valid && i_stall,
        o_valid && $stable(o_day_count), "stalled result beat changed")
endmodule

bind days_between_dates dbd_checker u_dbd_checker (.*);
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
    import dbd_pkg::*;

    localparam int DATE_W = YEAR_W + MONTH_W + DAY_W;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               ordered;
        logic               invalid;
    } t_span;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HOLD} t_stall_mode;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 i_stall        = 1'b0;
    logic [YEAR_W-1:0]    i_first_year   = '0;
    logic [MONTH_W-1:0]   i_first_month  = '0;
    logic [DAY_W-1:0]     i_first_day    = '0;
    logic [YEAR_W-1:0]    i_second_year  = '0;
    logic [MONTH_W-1:0]   i_second_month = '0;
    logic [DAY_W-1:0]     i_second_day   = '0;
    wire                  o_stall;
    wire                  o_valid;
    wire  [COUNT_W-1:0]   o_day_count;
    wire                  o_is_ordered;
    wire                  o_is_invalid;

    days_between_dates uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_day_count    (o_day_count),
        .o_is_ordered   (o_is_ordered),
        .o_is_invalid   (o_is_invalid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_span       span_q[$];
    t_span       want;
    int          mismatch_cnt = 0;
    int          beats_sent   = 0;
    int          results_seen = 0;
    int          n_ordered    = 0;
    int          n_unordered  = 0;
    int          n_invalid    = 0;
    int          gap_max      = 0;
    int          burst_left   = 0;
    int          hold_len     = 0;
    int          hold_cnt     = 0;
    int          held_cycles  = 0;
    int          pat_age      = 0;
    logic [7:0]  stall_pat    = 8'b0;
    t_stall_mode stall_mode   = STALL_NONE;

    // ---------------- date arithmetic ----------------

    function automatic logic is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        case (m)
            MON_FEB: return leap ? 29 : 28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic logic date_exists(input t_date dt);
        if (dt.year < 1 || dt.year > MAX_YEAR) return 1'b0;
        if (dt.month < MON_JAN || dt.month > MON_DEC) return 1'b0;
        return dt.day >= 1 && dt.day <= days_in_month(dt.month, is_leap(dt.year));
    endfunction

    // 1 January of year 1 is day 1
    function automatic int unsigned day_number(input t_date dt);
        int unsigned p;
        int unsigned n;
        logic [MONTH_W-1:0] k;
        p = dt.year - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (k = MON_JAN; k < dt.month; k++) n += days_in_month(k, is_leap(dt.year));
        return n + dt.day;
    endfunction

    function automatic t_span predict_span(input t_date a, input t_date b);
        t_span r;
        int unsigned na;
        int unsigned nb;
        r = '0;
        if (!date_exists(a) || !date_exists(b)) begin
            r.invalid = 1'b1;
        end else begin
            na = day_number(a);
            nb = day_number(b);
            if (na < nb) begin
                r.ordered = 1'b1;
                r.count   = COUNT_W'(nb - na);
            end
        end
        return r;
    endfunction

    function automatic t_date mk_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        t_date dt;
        dt.year  = YEAR_W'(y);
        dt.month = MONTH_W'(m);
        dt.day   = DAY_W'(d);
        return dt;
    endfunction

    function automatic t_date random_date(input int unsigned y_lo, input int unsigned y_hi);
        t_date dt;
        dt.year  = YEAR_W'($urandom_range(y_lo, y_hi));
        dt.month = MONTH_W'($urandom_range(MON_JAN, MON_DEC));
        dt.day   = DAY_W'($urandom_range(1, days_in_month(dt.month, is_leap(dt.year))));
        return dt;
    endfunction

    // ---------------- sender ----------------

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so a burst continues without a dropout.
    task automatic send_dates(input t_date a, input t_date b);
        int gap;
        t_span s;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_first_year   = a.year;
        i_first_month  = a.month;
        i_first_day    = a.day;
        i_second_year  = b.year;
        i_second_month = b.month;
        i_second_day   = b.day;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (o_stall);
        s = predict_span(a, b);
        span_q.push_back(s);
        beats_sent++;
        if (s.invalid) n_invalid++;
        else if (s.ordered) n_ordered++;
        else n_unordered++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        i_valid = 1'b0;
        burst_left = 0;
        while (span_q.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // ---------------- receiver ----------------

    always @(negedge i_clk) begin
        case (stall_mode)
            STALL_NONE: i_stall <= 1'b0;
            STALL_RANDOM: i_stall <= ($urandom_range(0, 99) < 35);
            STALL_PATTERN: begin
                i_stall <= stall_pat[0];
                if (pat_age == 0) stall_pat <= 8'($urandom());
                else stall_pat <= {stall_pat[0], stall_pat[7:1]};
                pat_age <= (pat_age == 63) ? 0 : pat_age + 1;
            end
            STALL_HOLD: begin
                i_stall <= (hold_cnt < hold_len);
                if (hold_cnt < hold_len) begin
                    hold_cnt    <= hold_cnt + 1;
                    held_cycles <= held_cycles + 1;
                end
            end
            default: i_stall <= 1'b0;
        endcase
        if (stall_mode != STALL_HOLD) hold_cnt <= 0;
    end

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (span_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("[%0t] unexpected beat: count=%0d ord=%b inv=%b",
                             $realtime, o_day_count, o_is_ordered, o_is_invalid);
            end else begin
                want = span_q.pop_front();
                if (o_day_count !== want.count || o_is_ordered !== want.ordered ||
                    o_is_invalid !== want.invalid) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("[%0t] exp cnt=%0d ord=%b inv=%b, got cnt=%0d ord=%b inv=%b",
                                 $realtime, want.count, want.ordered, want.invalid,
                                 o_day_count, o_is_ordered, o_is_invalid);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        gap_max = 3;
        stall_mode = STALL_RANDOM;
        send_dates(mk_date(1, 1, 1), mk_date(9999, 12, 31));     // widest span
        send_dates(mk_date(9999, 12, 31), mk_date(1, 1, 1));     // reversed
        send_dates(mk_date(2024, 5, 17), mk_date(2024, 5, 17));  // same day
        send_dates(mk_date(1999, 12, 31), mk_date(2000, 1, 1));
        send_dates(mk_date(2000, 2, 28), mk_date(2000, 3, 1));   // leap by 400
        send_dates(mk_date(1900, 2, 28), mk_date(1900, 3, 1));   // century, not leap
        send_dates(mk_date(2000, 2, 29), mk_date(2001, 2, 28));
        send_dates(mk_date(1900, 2, 29), mk_date(1901, 1, 1));   // bad leap day first
        send_dates(mk_date(2004, 1, 1), mk_date(2003, 2, 29));   // bad leap day second
        send_dates(mk_date(2021, 4, 31), mk_date(2022, 1, 1));   // past month end
        send_dates(mk_date(2021, 9, 31), mk_date(2022, 1, 1));
        send_dates(mk_date(2021, 1, 1), mk_date(2021, 11, 31));
        send_dates(mk_date(2020, 1, 1), mk_date(2020, 2, 30));
        send_dates(mk_date(2021, 6, 0), mk_date(2022, 1, 1));    // day zero
        send_dates(mk_date(2021, 0, 10), mk_date(2022, 1, 1));   // month zero
        send_dates(mk_date(2021, 1, 10), mk_date(2022, 13, 1));  // month 13
        send_dates(mk_date(16383, 15, 31), mk_date(16383, 15, 31));
        send_dates(mk_date(0, 0, 0), mk_date(0, 0, 0));
        send_dates(mk_date(0, 1, 1), mk_date(5, 1, 1));          // year zero
        send_dates(mk_date(1, 1, 1), mk_date(10000, 1, 1));      // year past max
        send_dates(mk_date(2023, 1, 31), mk_date(2023, 12, 31));
        send_dates(mk_date(9999, 12, 30), mk_date(9999, 12, 31));
        send_dates(mk_date(1, 1, 1), mk_date(1, 1, 2));
        send_dates(mk_date(2019, 2, 28), mk_date(2019, 3, 1));
        wait_results_done();
    endtask

    task automatic make_valid_pair(output t_date a, output t_date b);
        int kind;
        int unsigned y;
        t_date t;
        kind = $urandom_range(0, 9);
        a = random_date(1, MAX_YEAR);
        case (kind)
            0: b = a;
            1, 2, 3: begin
                y = a.year + $urandom_range(0, 1);
                if (y > MAX_YEAR) y = MAX_YEAR;
                b = random_date(y, y);
                if ($urandom_range(0, 1) == 1) begin
                    b.year  = a.year;
                    b.month = a.month;
                    b.day   = DAY_W'($urandom_range(1,
                              days_in_month(a.month, is_leap(a.year))));
                end
            end
            4: begin
                // years around leap rule edges
                case ($urandom_range(0, 2))
                    0: y = 4 * $urandom_range(1, 2499);
                    1: y = 100 * $urandom_range(1, 99);
                    default: y = 400 * $urandom_range(1, 24);
                endcase
                a = random_date(y, y);
                b = random_date(y, (y + 1 > MAX_YEAR) ? MAX_YEAR : y + 1);
            end
            default: b = random_date(1, MAX_YEAR);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    task automatic test_spread_dates(input int n);
        t_date a;
        t_date b;
        gap_max = 6;
        stall_mode = STALL_RANDOM;
        repeat (n) begin
            make_valid_pair(a, b);
            send_dates(a, b);
        end
        wait_results_done();
    endtask

    task automatic test_patterned_stall(input int n);
        t_date a;
        t_date b;
        gap_max = 2;
        stall_mode = STALL_PATTERN;
        repeat (n) begin
            make_valid_pair(a, b);
            send_dates(a, b);
        end
        wait_results_done();
    endtask

    task automatic test_malformed_dates(input int n);
        t_date a;
        t_date b;
        gap_max = 4;
        stall_mode = STALL_RANDOM;
        repeat (n) begin
            a = random_date(1, MAX_YEAR);
            b = random_date(1, MAX_YEAR);
            case ($urandom_range(0, 3))
                0: begin
                    a = t_date'(DATE_W'($urandom()));
                    b = t_date'(DATE_W'($urandom()));
                end
                1: b.day = ($urandom_range(0, 4) == 0) ? DAY_W'(0)
                                                       : DAY_W'($urandom_range(27, 31));
                2: begin
                    a.year = YEAR_W'($urandom_range(MAX_YEAR - 1, MAX_YEAR + 2));
                    if ($urandom_range(0, 1) == 1) a.year = YEAR_W'($urandom_range(0, 16383));
                end
                default: begin
                    a.month = ($urandom_range(0, 1) == 1) ? MONTH_W'(0)
                                                          : MONTH_W'($urandom_range(13, 15));
                    a.day   = DAY_W'($urandom_range(0, 31));
                end
            endcase
            if ($urandom_range(0, 1) == 1) send_dates(a, b);
            else send_dates(b, a);
        end
        wait_results_done();
    endtask

    // Receiver holds off for a long stretch while beats keep coming, so the
    // pipeline fills and the input stalls.
    task automatic test_backpressure(input int n);
        t_date a;
        t_date b;
        gap_max = 0;
        hold_len = 300;
        stall_mode = STALL_HOLD;
        repeat (n) begin
            make_valid_pair(a, b);
            send_dates(a, b);
        end
        wait_results_done();
        stall_mode = STALL_NONE;
    endtask

    task automatic test_full_rate(input int n);
        t_date a;
        t_date b;
        gap_max = 0;
        stall_mode = STALL_NONE;
        repeat (n) begin
            make_valid_pair(a, b);
            send_dates(a, b);
        end
        wait_results_done();
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_spread_dates(650);
        test_patterned_stall(300);
        test_malformed_dates(250);
        test_backpressure(100);
        test_full_rate(80);

        $display("Covered %0d beats: %0d ordered, %0d unordered, %0d invalid.",
                 beats_sent, n_ordered, n_unordered, n_invalid);
        $display("Checked %0d results; receiver held off %0d cycles; %0d mismatches.",
                 results_seen, held_cycles, mismatch_cnt);
        if (mismatch_cnt == 0 && span_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d results still pending", span_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
